// ===== src/cht_pkg.sv =====
package cht_pkg;

  localparam int MAX_BUCKETS_DEF  = 16;
  localparam int BUCKET_DEPTH_DEF = 8;

  localparam int KEY_W = 16;
  localparam int VER_W = 8;
  localparam int CMD_W = 2;
  localparam int STS_W = 2;
  localparam int CFG_W = 5;

  localparam logic [CFG_W-1:0] BUCKET_COUNT_RST = 5'd10;

  localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
  localparam logic [CMD_W-1:0] CMD_DELETE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_LOOKUP = 2'd2;

  localparam logic [STS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STS_W-1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [STS_W-1:0] ST_FULL      = 2'd2;

  typedef struct packed {
    logic             flag_b;
    logic             flag_a;
    logic [VER_W-1:0] version;
    logic [KEY_W-1:0] key;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  // status of the remainder unit toward the sequencer
  typedef struct packed {
    logic             done;
    logic [CFG_W-1:0] rem;
  } mod_res_t;

endpackage

// ===== src/cht_if.sv =====
interface cht_in_if import cht_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [CMD_W-1:0] cmd;
  logic [KEY_W-1:0] key;
  logic [VER_W-1:0] version;
  logic             flag_a;
  logic             flag_b;

  modport source (output valid, cmd, key, version, flag_a, flag_b, input ready);
  modport sink   (input valid, cmd, key, version, flag_a, flag_b, output ready);
endinterface

interface cht_out_if import cht_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [STS_W-1:0] status;
  logic [KEY_W-1:0] found_key;
  logic [VER_W-1:0] found_version;
  logic             found_flag_a;
  logic             found_flag_b;

  modport source (output valid, status, found_key, found_version, found_flag_a,
                  found_flag_b, input ready);
  modport sink   (input valid, status, found_key, found_version, found_flag_a,
                  found_flag_b, output ready);
endinterface

// ===== src/cht_mod.sv =====
// Restoring remainder, one dividend bit per cycle.
module cht_mod import cht_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [KEY_W-1:0] dividend,
  input  logic [CFG_W-1:0] divisor,
  output mod_res_t         res
);

  localparam int CNT_W = $clog2(KEY_W);

  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [KEY_W-1:0] dvd_r, dvd_nxt;
  logic [CFG_W-1:0] dsr_r, dsr_nxt;
  logic [CFG_W-1:0] rem_r, rem_nxt;
  logic [CFG_W:0]   trial;

  assign trial = {rem_r, dvd_r[KEY_W-1]};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    dvd_nxt  = dvd_r;
    dsr_nxt  = dsr_r;
    rem_nxt  = rem_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      dvd_nxt  = dividend;
      dsr_nxt  = divisor;
      rem_nxt  = '0;
    end else if (busy_r) begin
      if (trial >= {1'b0, dsr_r}) begin
        rem_nxt = CFG_W'(trial - {1'b0, dsr_r});
      end else begin
        rem_nxt = CFG_W'(trial);
      end
      dvd_nxt = {dvd_r[KEY_W-2:0], 1'b0};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CNT_W'(KEY_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    cnt_r <= cnt_nxt;
    dvd_r <= dvd_nxt;
    dsr_r <= dsr_nxt;
    rem_r <= rem_nxt;
  end

  assign res.done = done_r;
  assign res.rem  = rem_r;

endmodule

// ===== src/cht_ram.sv =====
// Single write port, single registered read port.
module cht_ram #(
  parameter int W     = 8,
  parameter int DEPTH = 16,
  parameter int AW    = 4
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [W-1:0]  wdata,
  input  logic [AW-1:0] raddr,
  output logic [W-1:0]  rdata
);

  logic [W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ===== src/chained_hash_table_engine.sv =====
// Channel   Dir  Handshake     Payload
// in_ch     in   valid/ready   cmd, key, version, flag_a, flag_b
// out_ch    out  valid/ready   status, found_key, found_version, found_flag_a, found_flag_b
// cfg       in   cfg_we        cfg_wdata (bucket_count)
//
// After reset the fill counts are cleared, one bucket a cycle, with in_ch.ready low. One
// transaction is worked on at a time: the remainder unit runs, the fill count is fetched and
// the command dispatched, slots are compared one by one and, on delete, the later slots are
// moved down one by one, then the output register is loaded and the engine goes back to
// idle. A result waiting on out_ch stalls only the final load step.
module chained_hash_table_engine import cht_pkg::*; #(
  parameter int MAX_BUCKETS  = MAX_BUCKETS_DEF,
  parameter int BUCKET_DEPTH = BUCKET_DEPTH_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  cht_in_if.sink           in_ch,
  cht_out_if.source        out_ch,
  input  logic             cfg_we,
  input  logic [CFG_W-1:0] cfg_wdata
);

  localparam int SLOTS  = MAX_BUCKETS * BUCKET_DEPTH;
  localparam int BKT_W  = (MAX_BUCKETS > 1) ? $clog2(MAX_BUCKETS) : 1;
  localparam int IDX_W  = (BUCKET_DEPTH > 1) ? $clog2(BUCKET_DEPTH) : 1;
  localparam int FILL_W = $clog2(BUCKET_DEPTH + 1);
  localparam int ADDR_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CLAMP  = (MAX_BUCKETS < 31) ? MAX_BUCKETS : 31;

  localparam logic [3:0] S_CLEAR  = 4'd0;
  localparam logic [3:0] S_IDLE   = 4'd1;
  localparam logic [3:0] S_MOD    = 4'd2;
  localparam logic [3:0] S_FREAD  = 4'd3;
  localparam logic [3:0] S_DISP   = 4'd4;
  localparam logic [3:0] S_SREAD  = 4'd5;
  localparam logic [3:0] S_SCMP   = 4'd6;
  localparam logic [3:0] S_DREAD  = 4'd7;
  localparam logic [3:0] S_DWRITE = 4'd8;
  localparam logic [3:0] S_FINISH = 4'd9;

  logic [3:0]        state_r, state_nxt;
  logic [CFG_W-1:0]  bucket_count_r;
  logic [CFG_W-1:0]  eff_buckets;
  logic [CMD_W-1:0]  cmd_r, cmd_nxt;
  entry_t            item_r, item_nxt;
  logic [BKT_W-1:0]  bucket_r, bucket_nxt;
  logic [BKT_W-1:0]  clr_cnt_r, clr_cnt_nxt;
  logic [FILL_W-1:0] fill_r, fill_nxt;
  logic [IDX_W-1:0]  idx_r, idx_nxt;
  logic [STS_W-1:0]  res_status_r, res_status_nxt;
  entry_t            res_entry_r, res_entry_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [STS_W-1:0]  out_status_r, out_status_nxt;
  entry_t            out_entry_r, out_entry_nxt;

  logic              accept;
  logic              mod_start;
  mod_res_t          mod_res;

  logic              fill_we;
  logic [BKT_W-1:0]  fill_waddr;
  logic [FILL_W-1:0] fill_wdata;
  logic [FILL_W-1:0] fill_rdata;

  logic              slot_we;
  logic [ADDR_W-1:0] slot_waddr;
  logic [ADDR_W-1:0] slot_raddr;
  logic [ADDR_W-1:0] base;
  entry_t            slot_wdata;
  logic [ENTRY_W-1:0] slot_rdata;
  entry_t            slot_entry;
  logic              last_idx;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bucket_count_r <= BUCKET_COUNT_RST;
    end else if (cfg_we) begin
      bucket_count_r <= cfg_wdata;
    end
  end

  always_comb begin
    if (bucket_count_r == '0) begin
      eff_buckets = CFG_W'(1);
    end else if (int'(bucket_count_r) > CLAMP) begin
      eff_buckets = CFG_W'(CLAMP);
    end else begin
      eff_buckets = bucket_count_r;
    end
  end

  assign accept    = in_ch.valid && in_ch.ready;
  assign mod_start = accept;

  cht_mod u_mod (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (mod_start),
    .dividend (in_ch.key),
    .divisor  (eff_buckets),
    .res      (mod_res)
  );

  cht_ram #(.W(FILL_W), .DEPTH(MAX_BUCKETS), .AW(BKT_W)) u_fill_ram (
    .clk   (clk),
    .we    (fill_we),
    .waddr (fill_waddr),
    .wdata (fill_wdata),
    .raddr (bucket_r),
    .rdata (fill_rdata)
  );

  cht_ram #(.W(ENTRY_W), .DEPTH(SLOTS), .AW(ADDR_W)) u_slot_ram (
    .clk   (clk),
    .we    (slot_we),
    .waddr (slot_waddr),
    .wdata (slot_wdata),
    .raddr (slot_raddr),
    .rdata (slot_rdata)
  );

  assign slot_entry = entry_t'(slot_rdata);
  assign base       = ADDR_W'(bucket_r) * ADDR_W'(BUCKET_DEPTH);
  assign last_idx   = (FILL_W'(idx_r) + FILL_W'(1)) == fill_r;

  always_comb begin
    if (state_r == S_DREAD) begin
      slot_raddr = base + ADDR_W'(idx_r) + ADDR_W'(1);
    end else begin
      slot_raddr = base + ADDR_W'(idx_r);
    end
  end

  always_comb begin
    state_nxt      = state_r;
    cmd_nxt        = cmd_r;
    item_nxt       = item_r;
    bucket_nxt     = bucket_r;
    clr_cnt_nxt    = clr_cnt_r;
    fill_nxt       = fill_r;
    idx_nxt        = idx_r;
    res_status_nxt = res_status_r;
    res_entry_nxt  = res_entry_r;
    out_valid_nxt  = out_valid_r;
    out_status_nxt = out_status_r;
    out_entry_nxt  = out_entry_r;
    fill_we        = 1'b0;
    fill_waddr     = bucket_r;
    fill_wdata     = '0;
    slot_we        = 1'b0;
    slot_waddr     = base + ADDR_W'(idx_r);
    slot_wdata     = slot_entry;

    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_CLEAR: begin
        fill_we     = 1'b1;
        fill_waddr  = clr_cnt_r;
        clr_cnt_nxt = clr_cnt_r + 1'b1;
        if (clr_cnt_r == BKT_W'(MAX_BUCKETS - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          cmd_nxt          = in_ch.cmd;
          item_nxt.key     = in_ch.key;
          item_nxt.version = in_ch.version;
          item_nxt.flag_a  = in_ch.flag_a;
          item_nxt.flag_b  = in_ch.flag_b;
          state_nxt        = S_MOD;
        end
      end
      S_MOD: begin
        if (mod_res.done) begin
          bucket_nxt = BKT_W'(mod_res.rem);
          state_nxt  = S_FREAD;
        end
      end
      S_FREAD: begin
        state_nxt = S_DISP;
      end
      S_DISP: begin
        fill_nxt       = fill_rdata;
        idx_nxt        = '0;
        res_status_nxt = ST_OK;
        res_entry_nxt  = '0;
        state_nxt      = S_FINISH;
        case (cmd_r)
          CMD_INSERT: begin
            if (fill_rdata == FILL_W'(BUCKET_DEPTH)) begin
              res_status_nxt = ST_FULL;
            end else begin
              slot_we    = 1'b1;
              slot_waddr = base + ADDR_W'(fill_rdata);
              slot_wdata = item_r;
              fill_we    = 1'b1;
              fill_wdata = fill_rdata + 1'b1;
            end
          end
          CMD_DELETE, CMD_LOOKUP: begin
            if (fill_rdata == '0) begin
              res_status_nxt = ST_NOT_FOUND;
            end else begin
              state_nxt = S_SREAD;
            end
          end
          default: begin
            res_status_nxt = ST_OK;
          end
        endcase
      end
      S_SREAD: begin
        state_nxt = S_SCMP;
      end
      S_SCMP: begin
        if (slot_entry.key == item_r.key) begin
          if (cmd_r == CMD_LOOKUP) begin
            res_entry_nxt = slot_entry;
            state_nxt     = S_FINISH;
          end else begin
            state_nxt = S_DREAD;
          end
        end else if (last_idx) begin
          res_status_nxt = ST_NOT_FOUND;
          state_nxt      = S_FINISH;
        end else begin
          idx_nxt   = idx_r + 1'b1;
          state_nxt = S_SREAD;
        end
      end
      S_DREAD: begin
        if (last_idx) begin
          fill_we    = 1'b1;
          fill_wdata = fill_r - 1'b1;
          state_nxt  = S_FINISH;
        end else begin
          state_nxt = S_DWRITE;
        end
      end
      S_DWRITE: begin
        // move the next slot down over the current one
        slot_we   = 1'b1;
        idx_nxt   = idx_r + 1'b1;
        state_nxt = S_DREAD;
      end
      S_FINISH: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_entry_nxt  = res_entry_r;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
    cmd_r        <= cmd_nxt;
    item_r       <= item_nxt;
    bucket_r     <= bucket_nxt;
    fill_r       <= fill_nxt;
    idx_r        <= idx_nxt;
    res_status_r <= res_status_nxt;
    res_entry_r  <= res_entry_nxt;
    out_status_r <= out_status_nxt;
    out_entry_r  <= out_entry_nxt;
  end

  assign in_ch.ready          = (state_r == S_IDLE);
  assign out_ch.valid         = out_valid_r;
  assign out_ch.status        = out_status_r;
  assign out_ch.found_key     = out_entry_r.key;
  assign out_ch.found_version = out_entry_r.version;
  assign out_ch.found_flag_a  = out_entry_r.flag_a;
  assign out_ch.found_flag_b  = out_entry_r.flag_b;

`ifndef SYNTH
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_we |-> int'(fill_wdata) <= BUCKET_DEPTH)
    else $error("fill count written above bucket depth");

  a_mod_done_state: assert property (@(posedge clk) disable iff (!rst_n)
    mod_res.done |-> state_r == S_MOD)
    else $error("remainder finished outside its wait state");

  a_slot_in_bucket: assert property (@(posedge clk) disable iff (!rst_n)
    slot_we |-> (slot_waddr >= base) && (int'(slot_waddr) < int'(base) + BUCKET_DEPTH))
    else $error("slot write outside the selected bucket");
`endif

endmodule

// ===== tb/sv/tb_chained_hash_table_engine.sv =====
`timescale 1ns / 100ps

module tb_chained_hash_table_engine;
  import cht_pkg::*;

  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
  localparam int NUM_BUCKETS      = MAX_BUCKETS_DEF;
  localparam int SLOTS_PER_BUCKET = BUCKET_DEPTH_DEF;
  localparam int NUM_PHASES       = 7;
  localparam int ITEMS_PER_PHASE  = 70;
  localparam int KEY_POOL_SIZE    = 20;
  localparam int PRESSURE_AT      = 150;
  localparam int PRESSURE_CYCLES  = 400;
  localparam int DRAIN_CYCLES     = 80;

  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic [KEY_W-1:0] key;
    logic [VER_W-1:0] version;
    logic             flag_a;
    logic             flag_b;
  } table_cmd_t;

  typedef struct packed {
    logic [STS_W-1:0] status;
    logic [KEY_W-1:0] key;
    logic [VER_W-1:0] version;
    logic             flag_a;
    logic             flag_b;
  } table_resp_t;

  typedef struct {
    table_cmd_t  c;
    bit          fixed;
    table_resp_t r;
  } directed_row_t;

  logic             clk;
  logic             rst_n;
  logic             cfg_we;
  logic [CFG_W-1:0] cfg_wdata;

  cht_in_if  in_ch ();
  cht_out_if out_ch ();

  chained_hash_table_engine dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  // shadow copy of the table
  entry_t           shadow_slots [NUM_BUCKETS][SLOTS_PER_BUCKET];
  int               shadow_fill [NUM_BUCKETS];
  logic [CFG_W-1:0] shadow_buckets;

  table_resp_t      expected_q[$];
  directed_row_t    directed_rows[$];
  logic [KEY_W-1:0] key_pool[$];

  int fail_count;
  int resp_count;
  int full_count;
  int miss_count;
  int cmd_count [4];
  bit calm;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("timeout with %0d results outstanding", expected_q.size());
    $display("CHECKS FAILED");
    $finish;
  end

  task automatic report_mismatch(input string msg);
    fail_count++;
    $display("[%0t] mismatch: %s", $time, msg);
  endtask

  function automatic table_resp_t apply_table_cmd(input table_cmd_t c);
    table_resp_t r;
    int nb;
    int b;
    int fill;
    int pos;
    r = '0;
    nb = (shadow_buckets == '0) ? 1 : int'(shadow_buckets);
    if (nb > NUM_BUCKETS) nb = NUM_BUCKETS;
    b = int'(c.key) % nb;
    fill = shadow_fill[b];
    // earliest entry with this key wins
    pos = fill;
    for (int i = fill - 1; i >= 0; i--) begin
      if (shadow_slots[b][i].key == c.key) pos = i;
    end
    case (c.cmd)
      CMD_INSERT: begin
        if (fill >= SLOTS_PER_BUCKET) begin
          r.status = ST_FULL;
        end else begin
          shadow_slots[b][fill].key     = c.key;
          shadow_slots[b][fill].version = c.version;
          shadow_slots[b][fill].flag_a  = c.flag_a;
          shadow_slots[b][fill].flag_b  = c.flag_b;
          shadow_fill[b] = fill + 1;
        end
      end
      CMD_DELETE: begin
        if (pos == fill) begin
          r.status = ST_NOT_FOUND;
        end else begin
          // close the gap
          for (int i = pos; i + 1 < fill; i++) shadow_slots[b][i] = shadow_slots[b][i + 1];
          shadow_fill[b] = fill - 1;
        end
      end
      CMD_LOOKUP: begin
        if (pos == fill) begin
          r.status = ST_NOT_FOUND;
        end else begin
          r.status  = ST_OK;
          r.key     = shadow_slots[b][pos].key;
          r.version = shadow_slots[b][pos].version;
          r.flag_a  = shadow_slots[b][pos].flag_a;
          r.flag_b  = shadow_slots[b][pos].flag_b;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic void add_row(input logic [CMD_W-1:0] cmd, input int key, input int ver,
                                  input bit fa, input bit fb, input bit fixed,
                                  input logic [STS_W-1:0] st, input int rk, input int rv,
                                  input bit ra, input bit rb);
    directed_row_t row;
    row.c.cmd     = cmd;
    row.c.key     = KEY_W'(key);
    row.c.version = VER_W'(ver);
    row.c.flag_a  = fa;
    row.c.flag_b  = fb;
    row.fixed     = fixed;
    row.r.status  = st;
    row.r.key     = KEY_W'(rk);
    row.r.version = VER_W'(rv);
    row.r.flag_a  = ra;
    row.r.flag_b  = rb;
    directed_rows.push_back(row);
  endfunction

  function automatic int pick_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 50);
  endfunction

  function automatic table_cmd_t random_cmd();
    table_cmd_t c;
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) begin
      c.cmd = CMD_INSERT;
    end else if (r < 65) begin
      c.cmd = CMD_DELETE;
    end else if (r < 95) begin
      c.cmd = CMD_LOOKUP;
    end else begin
      c.cmd = CMD_UNUSED;
    end
    // mostly reuse pool keys so deletes and lookups hit
    if ($urandom_range(0, 99) < 75) begin
      c.key = key_pool[$urandom_range(0, key_pool.size() - 1)];
    end else begin
      c.key = KEY_W'($urandom_range(0, 16'hFFFF));
    end
    c.version = VER_W'($urandom_range(0, 8'hFF));
    c.flag_a  = 1'($urandom_range(0, 1));
    c.flag_b  = 1'($urandom_range(0, 1));
    return c;
  endfunction

  task automatic send_cmd(input table_cmd_t c, input bit fixed, input table_resp_t want);
    table_resp_t pred;
    int gap;
    in_ch.valid   <= 1'b1;
    in_ch.cmd     <= c.cmd;
    in_ch.key     <= c.key;
    in_ch.version <= c.version;
    in_ch.flag_a  <= c.flag_a;
    in_ch.flag_b  <= c.flag_b;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    pred = apply_table_cmd(c);
    expected_q.push_back(fixed ? want : pred);
    cmd_count[c.cmd]++;
    gap = pick_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic write_bucket_count(input logic [CFG_W-1:0] value);
    // hold until the table is idle
    while (expected_q.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    shadow_buckets = value;
  endtask

  // result side: check each transaction, then decide ready for the next cycle
  initial begin
    int          hold_left;
    bit          pressure_done;
    bit          rdy;
    int          r;
    table_resp_t want;
    hold_left     = 0;
    pressure_done = 1'b0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
        if (expected_q.size() == 0) begin
          report_mismatch($sformatf("result %0d with nothing expected, status %0d",
                                    resp_count, out_ch.status));
        end else begin
          want = expected_q.pop_front();
          if (out_ch.status !== want.status)
            report_mismatch($sformatf("result %0d status %0d, want %0d",
                                      resp_count, out_ch.status, want.status));
          if (out_ch.found_key !== want.key)
            report_mismatch($sformatf("result %0d found_key %0h, want %0h",
                                      resp_count, out_ch.found_key, want.key));
          if (out_ch.found_version !== want.version)
            report_mismatch($sformatf("result %0d found_version %0h, want %0h",
                                      resp_count, out_ch.found_version, want.version));
          if (out_ch.found_flag_a !== want.flag_a)
            report_mismatch($sformatf("result %0d found_flag_a %b, want %b",
                                      resp_count, out_ch.found_flag_a, want.flag_a));
          if (out_ch.found_flag_b !== want.flag_b)
            report_mismatch($sformatf("result %0d found_flag_b %b, want %b",
                                      resp_count, out_ch.found_flag_b, want.flag_b));
          if (want.status == ST_FULL) full_count++;
          if (want.status == ST_NOT_FOUND) miss_count++;
        end
        resp_count++;
      end
      if (hold_left > 0) begin
        hold_left--;
        rdy = 1'b0;
      end else if (!pressure_done && resp_count >= PRESSURE_AT) begin
        // long hold so the engine backs up into its input
        pressure_done = 1'b1;
        hold_left     = PRESSURE_CYCLES - 1;
        rdy           = 1'b0;
      end else if (calm) begin
        rdy = 1'b1;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 70) begin
          rdy = 1'b1;
        end else if (r < 95) begin
          hold_left = $urandom_range(0, 3);
          rdy       = 1'b0;
        end else begin
          hold_left = $urandom_range(15, 60);
          rdy       = 1'b0;
        end
      end
      out_ch.ready <= rdy;
    end
  end

  initial begin
    logic [CFG_W-1:0] phase_counts [NUM_PHASES];
    in_ch.valid   <= 1'b0;
    in_ch.cmd     <= CMD_INSERT;
    in_ch.key     <= '0;
    in_ch.version <= '0;
    in_ch.flag_a  <= 1'b0;
    in_ch.flag_b  <= 1'b0;
    cfg_we        <= 1'b0;
    cfg_wdata     <= '0;
    rst_n         <= 1'b0;
    fail_count = 0;
    resp_count = 0;
    full_count = 0;
    miss_count = 0;
    calm       = 1'b0;
    foreach (cmd_count[i]) cmd_count[i] = 0;
    foreach (shadow_fill[i]) shadow_fill[i] = 0;
    shadow_buckets = BUCKET_COUNT_RST;

    // empty table at the reset bucket count of ten
    add_row(CMD_LOOKUP, 0, 0, 0, 0, 1, ST_NOT_FOUND, 0, 0, 0, 0);
    add_row(CMD_DELETE, 65535, 0, 0, 0, 1, ST_NOT_FOUND, 0, 0, 0, 0);
    add_row(CMD_UNUSED, 1234, 8'hAA, 1, 1, 1, ST_OK, 0, 0, 0, 0);
    add_row(CMD_INSERT, 0, 0, 0, 0, 1, ST_OK, 0, 0, 0, 0);
    add_row(CMD_INSERT, 65535, 255, 1, 1, 1, ST_OK, 0, 0, 0, 0);
    add_row(CMD_LOOKUP, 65535, 0, 0, 0, 1, ST_OK, 65535, 255, 1, 1);
    add_row(CMD_LOOKUP, 0, 0, 0, 0, 1, ST_OK, 0, 0, 0, 0);
    // duplicate key: first copy answers, delete exposes the second
    add_row(CMD_INSERT, 5, 1, 1, 0, 1, ST_OK, 0, 0, 0, 0);
    add_row(CMD_INSERT, 5, 2, 0, 1, 1, ST_OK, 0, 0, 0, 0);
    add_row(CMD_LOOKUP, 5, 0, 0, 0, 1, ST_OK, 5, 1, 1, 0);
    add_row(CMD_DELETE, 5, 0, 0, 0, 1, ST_OK, 0, 0, 0, 0);
    add_row(CMD_LOOKUP, 5, 0, 0, 0, 1, ST_OK, 5, 2, 0, 1);
    // fill bucket three, overflow it, then delete from the middle
    for (int i = 0; i < SLOTS_PER_BUCKET; i++)
      add_row(CMD_INSERT, 3 + 10 * i, 16 + i, bit'(i % 2), bit'(i / 4), 0,
              ST_OK, 0, 0, 0, 0);
    add_row(CMD_INSERT, 83, 0, 0, 0, 1, ST_FULL, 0, 0, 0, 0);
    add_row(CMD_DELETE, 33, 0, 0, 0, 0, ST_OK, 0, 0, 0, 0);
    add_row(CMD_LOOKUP, 43, 0, 0, 0, 0, ST_OK, 0, 0, 0, 0);
    add_row(CMD_LOOKUP, 33, 0, 0, 0, 0, ST_OK, 0, 0, 0, 0);

    phase_counts[0] = 5'd0;
    phase_counts[1] = 5'd31;
    phase_counts[2] = 5'd16;
    phase_counts[3] = 5'd1;
    phase_counts[4] = 5'd7;
    phase_counts[5] = 5'd16;
    phase_counts[6] = CFG_W'($urandom_range(2, 30));

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i]) send_cmd(directed_rows[i].c, directed_rows[i].fixed,
                                        directed_rows[i].r);
    in_ch.valid <= 1'b0;

    for (int p = 0; p < NUM_PHASES; p++) begin
      write_bucket_count(phase_counts[p]);
      key_pool.delete();
      repeat (KEY_POOL_SIZE) key_pool.push_back(KEY_W'($urandom_range(0, 16'hFFFF)));
      calm = (p == 2);
      repeat (ITEMS_PER_PHASE) send_cmd(random_cmd(), 1'b0, '0);
      in_ch.valid <= 1'b0;
    end
    calm = 1'b0;

    while (expected_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d inserts, %0d deletes, %0d lookups and %0d unused commands, %0d results",
             cmd_count[CMD_INSERT], cmd_count[CMD_DELETE], cmd_count[CMD_LOOKUP],
             cmd_count[CMD_UNUSED], resp_count);
    $display("%0d bucket-full and %0d not-found results over bucket counts 0 to 31, %0d errors",
             full_count, miss_count, fail_count);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
src/cht_pkg.sv
src/cht_if.sv
src/cht_mod.sv
src/cht_ram.sv
src/chained_hash_table_engine.sv
tb/sv/tb_chained_hash_table_engine.sv
